@@ rtl/core/qssg_pkg.sv @@
// Package for the quintic step slice generator: constants, controller states
// and the command/status structs shared by the controller and datapath.
package qssg_pkg;

	localparam int MAX_CHUNK_STEPS_DEF = 255;
	localparam int MAX_CHUNKS_DEF      = 64;
	localparam int TAU_FRAC_BITS_DEF   = 24;
	localparam int SLICE_TICKS_RESET   = 80000;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_MOVE_STEPS    = 2'd0;
	localparam logic [1:0] REG_SLICE_COUNT   = 2'd1;
	localparam logic [1:0] REG_TAU_PER_SLICE = 2'd2;
	localparam logic [1:0] REG_SLICE_TICKS   = 2'd3;

	// Multiplier operand selects.
	typedef enum logic [2:0] {
		MUL_TAU,
		MUL_T2,
		MUL_T3,
		MUL_T4,
		MUL_TOTAL
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TAU,
		ST_MUL,
		ST_POLY,
		ST_TARGET,
		ST_DIFF,
		ST_DIV,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic    clear;
		logic    calc_tau;
		logic    mul_go;
		mul_op_t mul_sel;
		logic    poly;
		logic    diff;
		logic    div_start;
		logic    div_step;
		logic    load_out;
		logic    commit;
	} qssg_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic skip;
		logic dwell;
		logic div_done;
		logic last_chunk;
	} qssg_sts_t;

endpackage

@@ rtl/core/qssg_ctrl.sv @@
// Controller state machine of the quintic step slice generator.
// Depends on qssg_pkg for states and the command/status structs.
module qssg_ctrl import qssg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_valid,
	input  logic      out_ready,
	input  qssg_sts_t sts,
	output qssg_cmd_t cmd,
	output logic      out_set
);

	state_t  state_q, state_nxt;
	mul_op_t mop_q, mop_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mop_q   <= MUL_TAU;
		end else begin
			state_q <= state_nxt;
			mop_q   <= mop_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		mop_nxt   = mop_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				state_nxt = sts.skip ? ST_IDLE : ST_TAU;
			end
			ST_TAU: begin
				state_nxt = ST_MUL;
				mop_nxt   = MUL_TAU;
			end
			ST_MUL: begin
				case (mop_q)
					MUL_TAU: mop_nxt = MUL_T2;
					MUL_T2:  mop_nxt = MUL_T3;
					MUL_T3:  mop_nxt = MUL_T4;
					MUL_T4: begin
						mop_nxt   = MUL_TOTAL;
						state_nxt = ST_POLY;
					end
					default: mop_nxt = MUL_T2;
				endcase
			end
			ST_POLY: begin
				mop_nxt   = MUL_TOTAL;
				state_nxt = ST_TARGET;
			end
			ST_TARGET: state_nxt = ST_DIFF;
			ST_DIFF:   state_nxt = ST_DIV;
			ST_DIV: begin
				if (sts.dwell || sts.div_done) state_nxt = ST_EMIT;
			end
			ST_EMIT: state_nxt = ST_WAIT;
			ST_WAIT: begin
				if (out_valid && out_ready) state_nxt = sts.last_chunk ? ST_IDLE : ST_EMIT;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd       = '0;
		cmd.mul_sel = mop_q;
		out_set   = 1'b0;
		in_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE:   cmd.clear = in_valid;
			ST_TAU:    cmd.calc_tau = 1'b1;
			ST_MUL:    cmd.mul_go = 1'b1;
			ST_TARGET: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MUL_TOTAL;
			end
			ST_POLY:   cmd.poly = 1'b1;
			ST_DIFF:   cmd.diff = 1'b1;
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_EMIT: begin
				cmd.load_out = 1'b1;
				out_set      = 1'b1;
			end
			ST_WAIT: begin
				if (out_valid && out_ready && sts.last_chunk) cmd.commit = 1'b1;
			end
			default: ;
		endcase
		if (state_q == ST_DIFF) cmd.div_start = 1'b1;
	end

endmodule

@@ rtl/core/qssg_dp.sv @@
// Datapath of the quintic step slice generator: configuration registers,
// polynomial multiplier, restoring divider and chunk counter.
// Depends on qssg_pkg.
module qssg_dp import qssg_pkg::*; #(
	parameter int MAX_CHUNK_STEPS = MAX_CHUNK_STEPS_DEF,
	parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF,
	parameter int TAU_FRAC_BITS   = TAU_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data,
	input  logic        start_req,
	input  qssg_cmd_t   cmd,
	input  logic        out_set,
	output qssg_sts_t   sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        dir_up,
	output logic [7:0]  chunk_steps,
	output logic [23:0] chunk_ticks,
	output logic        last
);

	localparam int TW = TAU_FRAC_BITS + 1;
	localparam int PW = 2 * TW;
	localparam logic [TW-1:0] ONE = TW'(1) << TAU_FRAC_BITS;
	localparam logic [PW-1:0] HALF = PW'(1) << (TAU_FRAC_BITS - 1);
	localparam int CW = $clog2(MAX_CHUNKS + 1);
	localparam logic signed [TW+5:0] K10 = (TW+6)'(10);
	localparam logic signed [TW+5:0] K15 = (TW+6)'(15);
	localparam logic signed [TW+5:0] K6  = (TW+6)'(6);

	logic [14:0] move_steps_q;
	logic [11:0] slice_count_q;
	logic [24:0] tau_per_slice_q;
	logic [23:0] slice_ticks_q;
	logic [11:0] slice_number_q;
	logic [13:0] steps_issued_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_steps_q    <= '0;
			slice_count_q   <= '0;
			tau_per_slice_q <= '0;
			slice_ticks_q   <= 24'(SLICE_TICKS_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MOVE_STEPS:    move_steps_q    <= cfg_data[14:0];
				REG_SLICE_COUNT:   slice_count_q   <= cfg_data[11:0];
				REG_TAU_PER_SLICE: tau_per_slice_q <= cfg_data[24:0];
				REG_SLICE_TICKS:   slice_ticks_q   <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Slice number and progress with start clearing.
	logic [11:0] sn_eff;
	logic [13:0] si_eff;
	logic        start_q;
	logic [12:0] idx;
	logic        neg;
	logic [14:0] mag;
	logic [13:0] total;
	logic        skip_w;

	assign sn_eff = start_q ? '0 : slice_number_q;
	assign si_eff = start_q ? '0 : steps_issued_q;
	assign idx    = {1'b0, sn_eff} + 13'd1;
	assign neg    = move_steps_q[14];
	assign mag    = neg ? (15'h0 - move_steps_q) : move_steps_q;
	assign total  = (mag > 15'd16383) ? 14'd16383 : mag[13:0];

	assign skip_w = (move_steps_q == '0) || (idx > {1'b0, slice_count_q});

	// tau, multiplier chain, polynomial and target.
	logic [TW-1:0] tau_q, t2_q, t3_q, t4_q, t5_q, pos_q;
	logic [13:0]   target_q, diff_q;
	logic [37:0]   tau_prod;
	logic [TW-1:0] ma, mb;
	logic [PW-1:0] mprod, mrnd;

	assign tau_prod = 38'(idx) * 38'(tau_per_slice_q);

	always_comb begin
		ma = tau_q;
		mb = tau_q;
		case (cmd.mul_sel)
			MUL_TAU:   ma = tau_q;
			MUL_T2:    ma = t2_q;
			MUL_T3:    ma = t3_q;
			MUL_T4:    ma = t4_q;
			MUL_TOTAL: begin
				ma = pos_q;
				mb = TW'(total);
			end
			default:   ma = tau_q;
		endcase
	end
	assign mprod = PW'(ma) * PW'(mb);
	assign mrnd  = (mprod + HALF) >> TAU_FRAC_BITS;

	// Minimum-jerk polynomial from the registered powers.
	logic signed [TW+5:0] t3x, t4x, t5x, poly;
	assign t3x  = $signed({6'b0, t3_q});
	assign t4x  = $signed({6'b0, t4_q});
	assign t5x  = $signed({6'b0, t5_q});
	assign poly = K10 * t3x - K15 * t4x + K6 * t5x;

	always_ff @(posedge clk) begin
		if (cmd.calc_tau) begin
			if (tau_prod > 38'(ONE) || idx == {1'b0, slice_count_q}) tau_q <= ONE;
			else tau_q <= tau_prod[TW-1:0];
		end
		if (cmd.mul_go) begin
			case (cmd.mul_sel)
				MUL_TAU:   t2_q <= mrnd[TW-1:0];
				MUL_T2:    t3_q <= mrnd[TW-1:0];
				MUL_T3:    t4_q <= mrnd[TW-1:0];
				MUL_T4:    t5_q <= mrnd[TW-1:0];
				MUL_TOTAL: target_q <= mrnd[13:0];
				default: ;
			endcase
		end
		if (cmd.poly) begin
			if (poly < 0) pos_q <= '0;
			else if (poly > $signed((TW+6)'(ONE))) pos_q <= ONE;
			else pos_q <= poly[TW-1:0];
		end
		if (cmd.diff) diff_q <= (target_q > si_eff) ? target_q - si_eff : '0;
	end

	// Restoring divider: slice_ticks / diff, one quotient bit per cycle.
	logic [23:0] quo_q;
	logic [14:0] rem_q;
	logic [4:0]  dcnt_q;
	logic [14:0] rtry;
	logic        div_done_q;
	assign rtry = {rem_q[13:0], slice_ticks_q[dcnt_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q     <= '0;
			div_done_q <= 1'b0;
		end else if (cmd.div_start) begin
			dcnt_q     <= 5'd23;
			div_done_q <= 1'b0;
		end else if (cmd.div_step && !div_done_q) begin
			dcnt_q <= dcnt_q - 5'd1;
			if (dcnt_q == 5'd0) div_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step && !div_done_q) begin
			if (rtry >= {1'b0, diff_q}) begin
				rem_q <= rtry - {1'b0, diff_q};
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= rtry;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	logic dwell_w;
	assign dwell_w = (diff_q == '0);

	// Chunk emission.
	logic [13:0]   left_q;
	logic [CW-1:0] nch_q;
	logic          first_q;
	logic [13:0]   left_cur, sz;
	logic          lst;

	assign left_cur = first_q ? diff_q : left_q;
	assign sz = (left_cur > 14'(MAX_CHUNK_STEPS)) ? 14'(MAX_CHUNK_STEPS) : left_cur;
	assign lst = dwell_w || (left_cur == sz) || (nch_q == CW'(MAX_CHUNKS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid      <= 1'b0;
			first_q        <= 1'b1;
			nch_q          <= '0;
			left_q         <= '0;
			slice_number_q <= '0;
			steps_issued_q <= '0;
			start_q        <= 1'b0;
		end else begin
			if (cmd.clear) start_q <= start_req;
			if (cmd.div_start) begin
				first_q <= 1'b1;
				nch_q   <= '0;
			end
			if (out_set) begin
				out_valid <= 1'b1;
				first_q   <= 1'b0;
				left_q    <= left_cur - sz;
				nch_q     <= nch_q + CW'(1);
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.commit) begin
				steps_issued_q <= target_q;
				slice_number_q <= idx[11:0];
				start_q        <= 1'b0;
			end else if (skip_w && start_q && !cmd.clear) begin
				slice_number_q <= '0;
				steps_issued_q <= '0;
				start_q        <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_set) begin
			dir_up      <= !neg;
			chunk_steps <= sz[7:0];
			chunk_ticks <= dwell_w ? slice_ticks_q : quo_q;
			last        <= lst;
		end
	end

	// Status back to the controller.
	assign sts = '{skip: skip_w, dwell: dwell_w, div_done: div_done_q, last_chunk: last};

endmodule

@@ rtl/core/quintic_step_slice_generator_top.sv @@
// Quintic minimum-jerk step slice generator.
// One request on the input channel is one time slice of the configured move.
// Configure move_steps, slice_count, tau_per_slice and slice_ticks through
// the write port while idle; start_req=1 marks the first slice of a move.
// Each slice yields one or more queue commands on the output channel, the
// final one flagged by last. A zero move or a slice past the end yields none.
// A request steps through tau, four powers, polynomial and target, then the
// restoring divider, which a dwell slice (zero steps to issue) leaves at once.
// The controller takes no new request until the last command of the slice
// is taken.
// A stalled receiver holds the command and pauses the block.
// Reset clears position and loads slice_ticks with 80000.
// Depends on qssg_pkg, qssg_ctrl and qssg_dp.
module quintic_step_slice_generator_top import qssg_pkg::*; #(
	parameter int MAX_CHUNK_STEPS = MAX_CHUNK_STEPS_DEF,
	parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF,
	parameter int TAU_FRAC_BITS   = TAU_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        start_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        dir_up,
	output logic [7:0]  chunk_steps,
	output logic [23:0] chunk_ticks,
	output logic        last
);

	qssg_cmd_t cmd;
	qssg_sts_t sts;
	logic      out_set;

	// Sequencer.
	qssg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd),
		.out_set(out_set)
	);

	// Arithmetic and state.
	qssg_dp #(
		.MAX_CHUNK_STEPS(MAX_CHUNK_STEPS), .MAX_CHUNKS(MAX_CHUNKS),
		.TAU_FRAC_BITS(TAU_FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start_req(start_req), .cmd(cmd), .out_set(out_set),
		.sts(sts), .out_valid(out_valid), .out_ready(out_ready),
		.dir_up(dir_up), .chunk_steps(chunk_steps), .chunk_ticks(chunk_ticks),
		.last(last)
	);

endmodule
